// ----- design/assert_macros.svh -----
// assertion macros shared by the execute unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define FRME_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`else
`define FRME_ASSERT(label, clk, rstn, prop, msg)
`endif

`ifndef SYNTH
`define FRME_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRME_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- design/frme_pkg.sv -----
// types, codes and helpers for the four-register execute unit
`default_nettype none

package frme_pkg;

    localparam int DATA_WIDTH   = 64;
    localparam int MEM_WORDS    = 1024;
    localparam int ADDR_W       = $clog2(MEM_WORDS);
    localparam int IMM_W        = 31;
    localparam int RAM_W        = DATA_WIDTH + 1;
    localparam int IN_FIELDS_W  = 3 + 2 + 2 + IMM_W + 2 + 2 + IMM_W + 3;
    localparam int IN_W         = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 3 + 1 + DATA_WIDTH;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0]      data_t;
    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [2:0]                 cmd_t;
    typedef logic [1:0]                 kind_t;
    typedef logic [1:0]                 reg_idx_t;
    typedef logic [IMM_W-1:0]           imm_t;
    typedef logic [2:0]                 cond_t;
    typedef logic [2:0]                 status_t;
    typedef logic [3:0][DATA_WIDTH-1:0] regfile_t;

    localparam cmd_t CMD_ADD = 3'd0;
    localparam cmd_t CMD_SUB = 3'd1;
    localparam cmd_t CMD_OR  = 3'd2;
    localparam cmd_t CMD_AND = 3'd3;
    localparam cmd_t CMD_NOT = 3'd4;
    localparam cmd_t CMD_MOV = 3'd5;
    localparam cmd_t CMD_CMP = 3'd6;
    localparam cmd_t CMD_JMP = 3'd7;

    localparam kind_t KIND_REG       = 2'd0;
    localparam kind_t KIND_IMM       = 2'd1;
    localparam kind_t KIND_MEM_CONST = 2'd2;
    localparam kind_t KIND_MEM_REG   = 2'd3;

    localparam cond_t COND_NONE = 3'd0;
    localparam cond_t COND_JE   = 3'd1;
    localparam cond_t COND_JNE  = 3'd2;
    localparam cond_t COND_JGE  = 3'd3;
    localparam cond_t COND_JL   = 3'd4;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_BAD_FIRST  = 3'd1;
    localparam status_t ST_BAD_SECOND = 3'd2;
    localparam status_t ST_UNWRITTEN  = 3'd3;
    localparam status_t ST_RANGE      = 3'd4;

    typedef struct packed {
        cmd_t     cmd;
        kind_t    first_kind;
        kind_t    second_kind;
        cond_t    condition;
        data_t    op_a;
        data_t    op_b;
        reg_idx_t dst_reg;
        logic     dst_ok;
        addr_t    dst_addr;
        logic     src_ok;
        logic     fwd_hit;
        data_t    fwd_data;
    } issue_item_t;

    typedef struct packed {
        logic     reg_we;
        reg_idx_t reg_idx;
        data_t    reg_data;
        logic     mem_we;
        addr_t    mem_addr;
        data_t    mem_data;
    } commit_t;

    function automatic data_t imm_to_data(input imm_t v);
        logic [IMM_W+DATA_WIDTH-1:0] wide;
        wide = {{DATA_WIDTH{1'b0}}, v};
        return wide[DATA_WIDTH-1:0];
    endfunction

    function automatic logic reg_addr_ok(input data_t a);
        return 64'(a) < 64'(MEM_WORDS);
    endfunction

    function automatic logic const_addr_ok(input imm_t v);
        return 64'(v) < 64'(MEM_WORDS);
    endfunction

endpackage

`default_nettype wire

// ----- design/frme_word_ram.sv -----
// single-port-write, single-port-read synchronous ram with registered read
`default_nettype none

module frme_word_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/frme_issue.sv -----
// issue stage: operand fetch with forwarding, address resolve, memory read launch
`default_nettype none

module frme_issue (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_accept,
    input  wire frme_pkg::cmd_t           cmd,
    input  wire frme_pkg::kind_t          first_kind,
    input  wire frme_pkg::reg_idx_t       first_reg,
    input  wire frme_pkg::imm_t           first_value,
    input  wire frme_pkg::kind_t          second_kind,
    input  wire frme_pkg::reg_idx_t       second_reg,
    input  wire frme_pkg::imm_t           second_value,
    input  wire frme_pkg::cond_t          condition,
    input  wire frme_pkg::regfile_t       regs,
    input  wire frme_pkg::commit_t        commit,
    input  wire logic                     b_ready,
    output      logic                     b_valid,
    output      frme_pkg::issue_item_t    b_item,
    output      logic                     ram_re,
    output      frme_pkg::addr_t          ram_raddr
);

    logic                  b_valid_reg;
    logic                  b_valid_next;
    frme_pkg::issue_item_t b_item_reg;
    frme_pkg::issue_item_t b_item_next;
    frme_pkg::regfile_t    rv;
    frme_pkg::addr_t       saddr;

    // register view after the instruction now committing
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (commit.reg_we && commit.reg_idx == 2'(i)) begin
                rv[i] = commit.reg_data;
            end else begin
                rv[i] = regs[i];
            end
        end
    end

    always_comb begin
        if (second_kind == frme_pkg::KIND_MEM_CONST) begin
            saddr = frme_pkg::ADDR_W'(second_value);
        end else begin
            saddr = frme_pkg::ADDR_W'(rv[second_reg]);
        end

        b_item_next.cmd         = cmd;
        b_item_next.first_kind  = first_kind;
        b_item_next.second_kind = second_kind;
        b_item_next.condition   = condition;
        b_item_next.op_a        = (first_kind == frme_pkg::KIND_REG) ? rv[first_reg]
                                  : frme_pkg::imm_to_data(first_value);
        b_item_next.op_b        = (second_kind == frme_pkg::KIND_REG) ? rv[second_reg]
                                  : frme_pkg::imm_to_data(second_value);
        b_item_next.dst_reg     = first_reg;
        if (first_kind == frme_pkg::KIND_MEM_CONST) begin
            b_item_next.dst_ok   = frme_pkg::const_addr_ok(first_value);
            b_item_next.dst_addr = frme_pkg::ADDR_W'(first_value);
        end else begin
            b_item_next.dst_ok   = frme_pkg::reg_addr_ok(rv[first_reg]);
            b_item_next.dst_addr = frme_pkg::ADDR_W'(rv[first_reg]);
        end
        if (second_kind == frme_pkg::KIND_MEM_CONST) begin
            b_item_next.src_ok = frme_pkg::const_addr_ok(second_value);
        end else begin
            b_item_next.src_ok = frme_pkg::reg_addr_ok(rv[second_reg]);
        end
        // ram reads old contents while the committing store lands
        b_item_next.fwd_hit  = commit.mem_we && (commit.mem_addr == saddr);
        b_item_next.fwd_data = commit.mem_data;
    end

    assign b_valid_next = b_ready ? s_accept : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            b_item_reg <= b_item_next;
        end
    end

    assign b_valid   = b_valid_reg;
    assign b_item    = b_item_reg;
    assign ram_re    = s_accept;
    assign ram_raddr = saddr;

endmodule

`default_nettype wire

// ----- design/frme_exec.sv -----
// execute stage: alu, compare, move, register file and output register
`default_nettype none

`include "assert_macros.svh"

module frme_exec (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               b_valid,
    input  wire frme_pkg::issue_item_t              b_item,
    input  wire logic [frme_pkg::RAM_W-1:0]         ram_rdata,
    output      logic                               b_ready,
    output      frme_pkg::regfile_t                 regs,
    output      frme_pkg::commit_t                  commit,
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [frme_pkg::OUT_W-1:0]         m_tdata
);

    localparam int WV_LO = 4;
    localparam int WV_HI = 3 + frme_pkg::DATA_WIDTH;

    frme_pkg::regfile_t              regs_reg;
    logic                            m_tvalid_reg;
    logic                            m_tvalid_next;
    logic [frme_pkg::OUT_W-1:0]      m_tdata_reg;
    logic [frme_pkg::OUT_W-1:0]      m_tdata_next;
    logic                            out_free;
    logic                            advance;
    logic                            mem_valid;
    frme_pkg::data_t                 mem_data;
    frme_pkg::data_t                 alu;
    frme_pkg::status_t               status;
    logic                            taken;
    frme_pkg::data_t                 wval;
    logic                            reg_we;
    logic                            mem_we;
    logic                            first_mem;
    logic                            second_mem;

    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = b_valid && out_free;
    assign b_ready  = !b_valid || out_free;

    assign mem_valid = b_item.fwd_hit ? 1'b1 : ram_rdata[frme_pkg::DATA_WIDTH];
    assign mem_data  = b_item.fwd_hit ? b_item.fwd_data
                       : ram_rdata[frme_pkg::DATA_WIDTH-1:0];

    assign first_mem  = (b_item.first_kind == frme_pkg::KIND_MEM_CONST) ||
                        (b_item.first_kind == frme_pkg::KIND_MEM_REG);
    assign second_mem = (b_item.second_kind == frme_pkg::KIND_MEM_CONST) ||
                        (b_item.second_kind == frme_pkg::KIND_MEM_REG);

    always_comb begin
        case (b_item.cmd)
            frme_pkg::CMD_ADD: alu = b_item.op_a + b_item.op_b;
            frme_pkg::CMD_SUB: alu = b_item.op_a - b_item.op_b;
            frme_pkg::CMD_OR:  alu = b_item.op_a | b_item.op_b;
            frme_pkg::CMD_AND: alu = b_item.op_a & b_item.op_b;
            default:           alu = ~b_item.op_a;
        endcase
    end

    always_comb begin
        status = frme_pkg::ST_OK;
        taken  = 1'b0;
        wval   = '0;
        reg_we = 1'b0;
        mem_we = 1'b0;
        case (b_item.cmd)
            frme_pkg::CMD_ADD, frme_pkg::CMD_SUB, frme_pkg::CMD_OR, frme_pkg::CMD_AND,
            frme_pkg::CMD_NOT: begin
                if (b_item.first_kind != frme_pkg::KIND_REG) begin
                    status = frme_pkg::ST_BAD_FIRST;
                end else if (b_item.cmd != frme_pkg::CMD_NOT && second_mem) begin
                    status = frme_pkg::ST_BAD_SECOND;
                end else begin
                    reg_we = 1'b1;
                    wval   = alu;
                end
            end
            frme_pkg::CMD_MOV: begin
                if (b_item.first_kind == frme_pkg::KIND_IMM) begin
                    status = frme_pkg::ST_BAD_FIRST;
                end else if (first_mem && !b_item.dst_ok) begin
                    status = frme_pkg::ST_RANGE;
                end else if (second_mem && !b_item.src_ok) begin
                    status = frme_pkg::ST_RANGE;
                end else if (second_mem && !mem_valid) begin
                    status = frme_pkg::ST_UNWRITTEN;
                end else begin
                    wval   = second_mem ? mem_data : b_item.op_b;
                    reg_we = !first_mem;
                    mem_we = first_mem;
                end
            end
            frme_pkg::CMD_CMP: begin
                if (b_item.first_kind != frme_pkg::KIND_REG &&
                    b_item.first_kind != frme_pkg::KIND_IMM) begin
                    status = frme_pkg::ST_BAD_FIRST;
                end else if (second_mem) begin
                    status = frme_pkg::ST_BAD_SECOND;
                end else begin
                    case (b_item.condition)
                        frme_pkg::COND_JE:  taken = (b_item.op_a == b_item.op_b);
                        frme_pkg::COND_JNE: taken = (b_item.op_a != b_item.op_b);
                        frme_pkg::COND_JGE: taken = (b_item.op_a >= b_item.op_b);
                        frme_pkg::COND_JL:  taken = (b_item.op_a < b_item.op_b);
                        default:            taken = 1'b0;
                    endcase
                end
            end
            default: begin
                taken = 1'b1;
            end
        endcase
    end

    assign commit.reg_we   = advance && reg_we;
    assign commit.reg_idx  = b_item.dst_reg;
    assign commit.reg_data = wval;
    assign commit.mem_we   = advance && mem_we;
    assign commit.mem_addr = b_item.dst_addr;
    assign commit.mem_data = wval;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (commit.reg_we) begin
            regs_reg[commit.reg_idx] <= commit.reg_data;
        end
    end

    assign m_tvalid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tdata_next  = frme_pkg::OUT_W'({wval, taken, status});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign regs     = regs_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FRME_ASSERT(a_fault_writes_nothing, aclk, aresetn,
        m_tvalid_reg && (m_tdata_reg[2:0] != frme_pkg::ST_OK) |->
            (m_tdata_reg[WV_HI:WV_LO] == '0) && !m_tdata_reg[3],
        "faulted instruction reports a write or branch")
    `FRME_ASSERT(a_item_reaches_output, aclk, aresetn,
        b_valid && out_free |=> m_tvalid_reg,
        "executed instruction missing from output")
    `FRME_ASSERT(a_single_destination, aclk, aresetn,
        !(commit.reg_we && commit.mem_we),
        "register and memory written together")

endmodule

`default_nettype wire

// ----- design/four_register_alu_machine_execute_unit.sv -----
// path: issue latch, then the m_tdata register; a busy output (m_tready low) stalls both
// one instruction per cycle if unstalled; register and store forwarding cover back-to-back use
// the word ram read is registered with the issue latch, so its data meets the item in execute
// reset: registers clear at once; a pass over all 1024 words then clears the word marks,
// s_tready stays low during that pass
`default_nettype none

`include "assert_macros.svh"

module four_register_alu_machine_execute_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // cmd, first_kind, first_reg, first_value, second_kind, second_reg, second_value, condition
    input  wire logic [frme_pkg::IN_W-1:0]     s_tdata,
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // status, branch_taken, written_value
    output      logic [frme_pkg::OUT_W-1:0]    m_tdata
);

    logic                         clr_busy_reg;
    logic                         clr_busy_next;
    frme_pkg::addr_t              clr_addr_reg;
    frme_pkg::addr_t              clr_addr_next;
    logic                         s_accept;
    logic                         b_ready;
    logic                         b_valid;
    frme_pkg::issue_item_t        b_item;
    frme_pkg::regfile_t           regs;
    frme_pkg::commit_t            commit;
    logic                         ram_re;
    frme_pkg::addr_t              ram_raddr;
    logic [frme_pkg::RAM_W-1:0]   ram_rdata;
    logic                         ram_we;
    frme_pkg::addr_t              ram_waddr;
    logic [frme_pkg::RAM_W-1:0]   ram_wdata;

    assign s_tready = !clr_busy_reg && b_ready;
    assign s_accept = s_tvalid && s_tready;

    assign clr_busy_next = clr_busy_reg &&
                           (clr_addr_reg != frme_pkg::ADDR_W'(frme_pkg::MEM_WORDS - 1));
    assign clr_addr_next = clr_addr_reg + frme_pkg::ADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // word mark in the top bit
    assign ram_we    = clr_busy_reg || commit.mem_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : commit.mem_addr;
    assign ram_wdata = clr_busy_reg ? '0 : {1'b1, commit.mem_data};

    frme_word_ram #(
        .WIDTH (frme_pkg::RAM_W),
        .DEPTH (frme_pkg::MEM_WORDS),
        .AW    (frme_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    frme_issue u_issue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_accept     (s_accept),
        .cmd          (s_tdata[2:0]),
        .first_kind   (s_tdata[4:3]),
        .first_reg    (s_tdata[6:5]),
        .first_value  (s_tdata[37:7]),
        .second_kind  (s_tdata[39:38]),
        .second_reg   (s_tdata[41:40]),
        .second_value (s_tdata[72:42]),
        .condition    (s_tdata[75:73]),
        .regs         (regs),
        .commit       (commit),
        .b_ready      (b_ready),
        .b_valid      (b_valid),
        .b_item       (b_item),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr)
    );

    frme_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .b_valid   (b_valid),
        .b_item    (b_item),
        .ram_rdata (ram_rdata),
        .b_ready   (b_ready),
        .regs      (regs),
        .commit    (commit),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `FRME_ASSERT(a_no_transfer_while_clearing, aclk, aresetn,
        s_accept |-> !clr_busy_reg,
        "input transfer during mark clearing")
    `FRME_ASSERT(a_no_store_while_clearing, aclk, aresetn,
        commit.mem_we |-> !clr_busy_reg,
        "store collides with mark clearing")
    `FRME_ASSERT(a_pipe_empty_while_clearing, aclk, aresetn,
        clr_busy_reg |-> !b_valid && !m_tvalid,
        "instruction in flight during mark clearing")

endmodule

`default_nettype wire
